/* rtl/core/urlpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder - shared package
// Types, codes, character constants and the hex digit decode used by the
// decoder core, the result queue and the checker.
// ----------------------------------------------------------------------------
package urlpd_pkg;

    // Counter width default (produced and consumed counters)
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Result queue depth: room for two items of results in flight
    localparam int unsigned RES_DEPTH = 4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LIMIT   = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] DEST_CAPACITY_RST = 16'hFFFF;
    localparam logic        LIMIT_ENABLE_RST  = 1'b0;
    localparam logic [15:0] INPUT_LIMIT_RST   = 16'hFFFF;

    // Character constants
    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_DIGIT0  = 8'h30;
    localparam logic [7:0] CHR_DIGIT9  = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_F = 8'h46;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_F = 8'h66;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_PERCENT  = 2'd1,
        MODE_FIRSTNIB = 2'd2
    } t_mode;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_end;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } t_result;

    // Results caused by one item: data slot first, end slot second
    typedef struct packed {
        logic    data_vld;
        t_result data_res;
        logic    end_vld;
        t_result end_res;
    } t_push;

    // Hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[CHR_DIGIT0:CHR_DIGIT9]}) begin
            res = {1'b1, 4'(c - CHR_DIGIT0)};
        end else if (c inside {[CHR_UPPER_A:CHR_UPPER_F]}) begin
            res = {1'b1, 4'(c - CHR_UPPER_A + 8'd10)};
        end else if (c inside {[CHR_LOWER_A:CHR_LOWER_F]}) begin
            res = {1'b1, 4'(c - CHR_LOWER_A + 8'd10)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/urlpd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder - decode core
// Holds the configuration registers and the per-string state, and turns one
// registered character into at most one data result and one end result.
// ----------------------------------------------------------------------------
module urlpd_core
    import urlpd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_go,
    input  wire logic [7:0]            i_char,
    input  wire logic                  i_last,
    output t_push                      o_push
);

    // Width used for comparisons against the 16-bit registers
    localparam int unsigned EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [15:0]            r_dest_capacity;
    logic                   r_limit_enable;
    logic [15:0]            r_input_limit;

    t_mode                  r_mode,     n_mode;
    logic [3:0]             r_high_nib, n_high_nib;
    logic [COUNT_WIDTH-1:0] r_produced, n_produced;
    logic [COUNT_WIDTH-1:0] r_consumed, n_consumed;
    logic [1:0]             r_err,      n_err;

    logic       take;
    logic       no_room;
    logic [4:0] hex;
    logic       emit;
    logic [7:0] emit_byte;
    logic [1:0] end_status;
    logic [EW-1:0] prod_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_capacity <= DEST_CAPACITY_RST;
            r_limit_enable  <= LIMIT_ENABLE_RST;
            r_input_limit   <= INPUT_LIMIT_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_DEST_CAPACITY: r_dest_capacity <= i_cfg_wdata;
                CFG_LIMIT_ENABLE:  r_limit_enable  <= i_cfg_wdata[0];
                CFG_INPUT_LIMIT:   r_input_limit   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item qualification and room check
    assign take = (i_char != CHR_NUL) && (r_err == ST_OK) &&
                  !(r_limit_enable && (EW'(r_consumed) >= EW'(r_input_limit)));
    assign no_room = (EW'(r_produced) >= EW'(r_dest_capacity)) ||
                     (r_produced == CNT_MAX);
    assign hex = hex_decode(i_char);

    // Next state and results
    always_comb begin
        n_mode     = r_mode;
        n_high_nib = r_high_nib;
        n_produced = r_produced;
        n_consumed = r_consumed;
        n_err      = r_err;
        emit       = 1'b0;
        emit_byte  = i_char;
        end_status = ST_OK;

        if (take) begin
            if (r_consumed != CNT_MAX) begin
                n_consumed = r_consumed + 1'b1;
            end
            case (r_mode)
                MODE_PERCENT: begin
                    if (!hex[4]) begin
                        n_err = ST_INVALID;
                    end else begin
                        n_high_nib = hex[3:0];
                        n_mode     = MODE_FIRSTNIB;
                    end
                end
                MODE_FIRSTNIB: begin
                    // space is checked before the digit
                    if (no_room) begin
                        n_err = ST_NOSPACE;
                    end else if (!hex[4]) begin
                        n_err = ST_INVALID;
                    end else begin
                        emit       = 1'b1;
                        emit_byte  = {r_high_nib, hex[3:0]};
                        n_high_nib = 4'd0;
                        n_mode     = MODE_NORMAL;
                    end
                end
                default: begin
                    if (i_char == CHR_PERCENT) begin
                        n_mode = MODE_PERCENT;
                    end else if (no_room) begin
                        n_err = ST_NOSPACE;
                    end else begin
                        emit = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                n_produced = r_produced + 1'b1;
            end
        end

        // end status: unfinished escape counts as invalid
        end_status = n_err;
        if (n_err == ST_OK && n_mode != MODE_NORMAL) begin
            end_status = ST_INVALID;
        end
        prod_ext = EW'(n_produced);

        o_push.data_vld            = i_go && emit;
        o_push.data_res.out_byte   = emit_byte;
        o_push.data_res.is_end     = 1'b0;
        o_push.data_res.status     = ST_OK;
        o_push.data_res.byte_count = prod_ext[15:0];
        o_push.end_vld             = i_go && i_last;
        o_push.end_res.out_byte    = 8'd0;
        o_push.end_res.is_end      = 1'b1;
        o_push.end_res.status      = end_status;
        o_push.end_res.byte_count  = prod_ext[15:0];

        // last item rearms the decoder
        if (i_last) begin
            n_mode     = MODE_NORMAL;
            n_high_nib = 4'd0;
            n_produced = '0;
            n_consumed = '0;
            n_err      = ST_OK;
        end
    end

    // Per-string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_high_nib <= 4'd0;
            r_produced <= '0;
            r_consumed <= '0;
            r_err      <= ST_OK;
        end else if (i_go) begin
            r_mode     <= n_mode;
            r_high_nib <= n_high_nib;
            r_produced <= n_produced;
            r_consumed <= n_consumed;
            r_err      <= n_err;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/urlpd_resq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder - result queue
// Small register queue that takes up to two results per cycle in order and
// presents the oldest one to the output stream.
// ----------------------------------------------------------------------------
module urlpd_resq
    import urlpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    output logic      o_room2,
    output logic      o_valid,
    output t_result   o_res,
    input  wire logic i_pop
);

    localparam int unsigned PW = $clog2(RES_DEPTH);
    localparam int unsigned CW = $clog2(RES_DEPTH + 1);

    t_result         r_mem [RES_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic [PW-1:0]   end_ptr;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CW'(RES_DEPTH - 2));
    assign pop     = i_pop && o_valid;
    assign end_ptr = i_push.data_vld ? PW'(r_wr_ptr + 1'b1) : r_wr_ptr;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = PW'(r_wr_ptr + PW'(i_push.data_vld) + PW'(i_push.end_vld));
        n_rd_ptr = pop ? PW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = CW'(r_count + CW'(i_push.data_vld) + CW'(i_push.end_vld)
                       - CW'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: data result first, end result behind it
    always_ff @(posedge i_clk) begin
        if (i_push.data_vld) begin
            r_mem[r_wr_ptr] <= i_push.data_res;
        end
        if (i_push.end_vld) begin
            r_mem[end_ptr] <= i_push.end_res;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/url_percent_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder - top level
// Decodes a stream of percent-encoded characters into bytes, one character
// per item, with an end-of-string status item after the last character.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while the queue has room. Each accepted
// item is held in an input register and decoded by the core once the result
// queue has room for two results. Its results (a data byte, an end status, or
// both) go into a four-entry result queue as the item leaves the input
// register. The input keeps taking an item every cycle as long as the queue has
// room for two results; an item that yields both a byte and an end status puts
// two items into the queue, which drains at one per cycle while m_axis_tready
// is high. Errors are sticky until the item with tlast; the end item carries
// the status in tuser and the byte count in tdata, then the decoder starts
// afresh. The user writes the configuration registers (index 0 destination
// capacity, 1 limit enable, 2 input limit) through i_cfg_* while the stream
// is idle; the block does not enforce this.
module url_percent_decoder_unit
    import urlpd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // encoded character stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] in_char
    input  wire logic                  s_axis_tlast,  // in_last
    // decoded result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // [7:0] out_byte, [23:8] byte_count
    output logic                       m_axis_tlast,  // is_end
    output logic [1:0]                 m_axis_tuser   // status
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       room2;
    logic       go;
    logic       in_acc;
    t_push      push;
    t_result    head;

    // Input register stage
    assign go            = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    urlpd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_go        (go),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .o_push      (push)
    );

    urlpd_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .o_res   (head),
        .i_pop   (m_axis_tready)
    );

    // Output packing
    assign m_axis_tdata = {head.byte_count, head.out_byte};
    assign m_axis_tlast = head.is_end;
    assign m_axis_tuser = head.status;

endmodule
`default_nettype wire

/* rtl/core/urlpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder - port checker
// Watches the top-level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
module urlpd_checker
    import urlpd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [23:0]           m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic [1:0]            m_axis_tuser
);

    // Queue comes out of reset empty
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result item shown straight after reset");

    // Data items always carry ok status
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ST_OK))
        else $error("data item with non-ok status");

    // End items carry a zero byte and a defined status
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        ((m_axis_tdata[7:0] == 8'd0) &&
         (m_axis_tuser == ST_OK || m_axis_tuser == ST_NOSPACE ||
          m_axis_tuser == ST_INVALID)))
        else $error("malformed end item");

    // Consecutive data items of one string count up by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1
        (m_axis_tvalid && !m_axis_tlast) |->
        (m_axis_tdata[23:8] == 16'($past(m_axis_tdata[23:8]) + 16'd1)))
        else $error("byte count did not step by one");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
         $stable(m_axis_tuser)))
        else $error("stalled result item changed");

endmodule

bind url_percent_decoder_unit urlpd_checker u_urlpd_checker (.*);
`default_nettype wire

/* test/url_percent_decoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder - unit testbench
// Drives percent-encoded strings into the decoder under random source gaps and
// sink stalls, predicts every decoded byte and end-of-string status in a
// local model of the decoder, and compares each result field by field.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit_test;
    import urlpd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 950;
    localparam int LONG_ITEMS    = 40;

    // clock, reset, configuration port
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_DEST_CAPACITY;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // character stream in, result stream out
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_char
    logic s_axis_tlast = 1'b0;          // in_last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [7:0] out_byte, [23:8] byte_count
    logic m_axis_tlast;                 // is_end
    logic [1:0] m_axis_tuser;           // status

    // decoder model: registers and per-string state
    logic [15:0] mdl_capacity = 16'hFFFF;
    logic mdl_limit_en = 1'b0;
    logic [15:0] mdl_input_limit = 16'hFFFF;
    t_mode mdl_mode = MODE_NORMAL;
    logic [3:0] mdl_high_nibble = 4'h0;
    logic [15:0] mdl_produced = 16'h0000;
    logic [15:0] mdl_consumed = 16'h0000;
    logic [1:0] mdl_error = ST_OK;

    t_result pending_results[$];

    // bookkeeping
    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int decoded_items = 0;
    int strings_sent = 0;
    int results_checked = 0;
    int stall_left = 0;
    bit src_idle_en = 1'b0;
    bit sink_stall_en = 1'b0;

    url_percent_decoder_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[url_percent_decoder_unit] ERROR");
            $finish;
        end
    end

    // sink: random stall bursts, with tready held low
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // hex digit value, -1 when the character is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) return int'(c - CHR_DIGIT0);
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) return int'(c - CHR_UPPER_A) + 10;
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) return int'(c - CHR_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic bit dest_full();
        return mdl_produced >= mdl_capacity || mdl_produced == 16'hFFFF;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic e,
                                         input logic [1:0] st, input logic [15:0] cnt);
        t_result r;
        r.out_byte = b;
        r.is_end = e;
        r.status = st;
        r.byte_count = cnt;
        pending_results.push_back(r);
    endfunction

    // decode one accepted character into the expected results
    function automatic void predict_decode(input logic [7:0] c, input logic last);
        int nib;
        logic [1:0] end_status;
        if (c != CHR_NUL && mdl_error == ST_OK &&
            !(mdl_limit_en && mdl_consumed >= mdl_input_limit)) begin
            decoded_items++;
            if (mdl_consumed != 16'hFFFF) mdl_consumed++;
            case (mdl_mode)
                MODE_PERCENT: begin
                    nib = hex_nibble(c);
                    if (nib < 0) begin
                        mdl_error = ST_INVALID;
                    end else begin
                        mdl_high_nibble = nib[3:0];
                        mdl_mode = MODE_FIRSTNIB;
                    end
                end
                MODE_FIRSTNIB: begin
                    // space is checked before the digit
                    nib = hex_nibble(c);
                    if (dest_full()) begin
                        mdl_error = ST_NOSPACE;
                    end else if (nib < 0) begin
                        mdl_error = ST_INVALID;
                    end else begin
                        mdl_produced++;
                        queue_result({mdl_high_nibble, nib[3:0]}, 1'b0, ST_OK, mdl_produced);
                        mdl_high_nibble = 4'h0;
                        mdl_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (c == CHR_PERCENT) begin
                        mdl_mode = MODE_PERCENT;
                    end else if (dest_full()) begin
                        mdl_error = ST_NOSPACE;
                    end else begin
                        mdl_produced++;
                        queue_result(c, 1'b0, ST_OK, mdl_produced);
                    end
                end
            endcase
        end
        if (last) begin
            // a string cut off inside an escape is invalid
            end_status = mdl_error;
            if (end_status == ST_OK && mdl_mode != MODE_NORMAL) end_status = ST_INVALID;
            queue_result(8'h00, 1'b1, end_status, mdl_produced);
            mdl_mode = MODE_NORMAL;
            mdl_high_nibble = 4'h0;
            mdl_produced = 16'h0000;
            mdl_consumed = 16'h0000;
            mdl_error = ST_OK;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_byte = m_axis_tdata[7:0];
            got.byte_count = m_axis_tdata[23:8];
            got.is_end = m_axis_tlast;
            got.status = m_axis_tuser;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte=0x%02h end=%0b st=%0d cnt=%0d",
                                          got.out_byte, got.is_end, got.status,
                                          got.byte_count));
            end else begin
                want = pending_results.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch($sformatf("result %0d out_byte 0x%02h, expected 0x%02h",
                                              results_checked, got.out_byte, want.out_byte));
                if (got.is_end !== want.is_end)
                    report_mismatch($sformatf("result %0d is_end %0b, expected %0b",
                                              results_checked, got.is_end, want.is_end));
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_checked, got.status, want.status));
                if (got.byte_count !== want.byte_count)
                    report_mismatch($sformatf("result %0d byte_count %0d, expected %0d",
                                              results_checked, got.byte_count,
                                              want.byte_count));
            end
            results_checked++;
        end
    end

    // send one item, with an optional source gap in front
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_decode(c, last);
        items_sent++;
        if (last) strings_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // stop the source and let the block go quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] capacity, input logic limit_en,
                              input logic [15:0] limit);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= CFG_DEST_CAPACITY;
        i_cfg_wdata <= capacity;
        @(posedge i_clk);
        i_cfg_idx <= CFG_LIMIT_ENABLE;
        i_cfg_wdata <= {15'd0, limit_en};
        @(posedge i_clk);
        i_cfg_idx <= CFG_INPUT_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        mdl_capacity = capacity;
        mdl_limit_en = limit_en;
        mdl_input_limit = limit;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CHR_DIGIT0 + 8'(v);
        if ($urandom_range(0, 1) == 1) return CHR_UPPER_A + 8'(v) - 8'd10;
        return CHR_LOWER_A + 8'(v) - 8'd10;
    endfunction

    // escapes in both cases, bytes at the extremes, zero skipping, bad escapes
    task automatic test_directed_strings();
        wait_idle();
        src_idle_en = 1'b1;
        sink_stall_en = 1'b1;
        send_text("%41%7e%fF");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(CHR_NUL, 1'b1);       // last on a skipped character
        send_text("%Gab");              // non-hex after percent, then ignored
        send_text("%4x");               // bad second nibble
        send_text("%A");                // ends after the first nibble
        send_text("%");                 // ends right after percent
    endtask

    // destination capacity, including no room at the second nibble
    task automatic test_capacity_limits();
        wait_idle();
        set_config(16'd0, 1'b0, 16'hFFFF);
        send_text("a");
        wait_idle();
        set_config(16'd2, 1'b0, 16'hFFFF);
        send_text("ab%41");
        send_text("abc");
        send_text("%00%ff%");
    endtask

    // input length limit, at zero, small and maximum
    task automatic test_input_limits();
        wait_idle();
        set_config(16'hFFFF, 1'b1, 16'd3);
        send_text("abcdef");
        wait_idle();
        set_config(16'hFFFF, 1'b1, 16'd0);
        send_text("xyz");
        wait_idle();
        set_config(16'hFFFF, 1'b1, 16'd2);
        send_text("%41");               // limit falls inside the escape
        wait_idle();
        set_config(16'hFFFF, 1'b1, 16'hFFFF);
        send_text("%2a%2B.");
    endtask

    // one random string, mostly well formed escapes and plain characters
    task automatic send_random_string();
        logic [7:0] chars[$];
        logic [7:0] c;
        int len;
        int pick;
        int i;
        len = $urandom_range(1, 16);
        while (chars.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                do c = 8'($urandom_range(1, 255)); while (c == CHR_PERCENT);
                chars.push_back(c);
            end else if (pick < 78) begin
                chars.push_back(CHR_PERCENT);
                chars.push_back(hex_char(4'($urandom_range(0, 15))));
                chars.push_back(hex_char(4'($urandom_range(0, 15))));
            end else if (pick < 83) begin
                chars.push_back(CHR_NUL);
            end else if (pick < 88) begin
                chars.push_back(CHR_PERCENT);
                if ($urandom_range(0, 1) == 1)
                    chars.push_back(hex_char(4'($urandom_range(0, 15))));
                do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) >= 0);
                chars.push_back(c);
            end else if (pick < 93) begin
                chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                // unfinished escape
                chars.push_back(CHR_PERCENT);
                if ($urandom_range(0, 1) == 1)
                    chars.push_back(hex_char(4'($urandom_range(0, 15))));
            end
        end
        for (i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
    endtask

    // random phases, each under its own register setting
    task automatic test_random_streams();
        int start_items;
        int phase_end;
        logic [15:0] capacity;
        logic [15:0] limit;
        logic limit_en;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: capacity = 16'd0;
                1: capacity = 16'hFFFF;
                2: capacity = 16'($urandom_range(0, 65535));
                3: capacity = 16'($urandom_range(1, 24));
                default: capacity = 16'($urandom_range(100, 65535));
            endcase
            limit_en = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 3))
                0: limit = 16'd0;
                1: limit = 16'hFFFF;
                2: limit = 16'($urandom_range(0, 65535));
                default: limit = 16'($urandom_range(1, 30));
            endcase
            set_config(capacity, limit_en, limit);
            // no idling in the closing stretch
            if (items_sent - start_items > RANDOM_ITEMS - 150) begin
                src_idle_en = 1'b0;
                sink_stall_en = 1'b0;
            end else begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                sink_stall_en = ($urandom_range(0, 3) != 0);
            end
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end) send_random_string();
        end
    endtask

    // one long unbroken string of plain characters, sent back to back
    task automatic test_long_string();
        logic [7:0] c;
        int i;
        wait_idle();
        src_idle_en = 1'b0;
        sink_stall_en = 1'b0;
        set_config(16'hFFFF, 1'b0, 16'hFFFF);
        for (i = 0; i < LONG_ITEMS; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == CHR_PERCENT);
            send_char(c, i == LONG_ITEMS - 1);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_strings();
        test_capacity_limits();
        test_input_limits();
        test_random_streams();
        test_long_string();
        wait_idle();

        $display("Ran %0d strings of %0d characters (%0d decoded), checked %0d results",
                 strings_sent, items_sent, decoded_items, results_checked);
        $display("Settings covered: zero and full capacity, limit off/on at 0, small and max");
        if (error_count == 0) begin
            $display("[url_percent_decoder_unit] OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[url_percent_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule
